/* rtl/assert_macros.svh */
// Assertion macros used by the top RTL file of the cluster allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define AST_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never becomes true outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/fca_pkg.sv */
// Package with types and constants of the FAT cluster allocator.
package fca_pkg;

    localparam int CLUSTER_W          = 16;
    localparam int ENTRY_W            = 28;
    localparam int SPF_W              = 10;
    localparam int SPF_RESET          = 512;
    localparam int ENTRIES_PER_SECTOR = 128;
    localparam int SECTOR_SHIFT       = 7;

    localparam logic [ENTRY_W-1:0] END_OF_CHAIN = 28'h0FFFFFFF;

    typedef enum logic [1:0] {
        CMD_QUERY = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_LOAD  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_QDATA,
        S_SCAN,
        S_LINK,
        S_MARK,
        S_RESP
    } t_state;

endpackage

/* rtl/fca_ram.sv */
// Single-clock table memory with one write port and one registered read port.
module fca_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 28,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fat_cluster_allocator_top.sv */
// FAT cluster table with query, load and allocate commands, one item at a time.
// Load and rejected items go from decode straight to the response; a query first reads the
// table, and allocate scans from the hint for a free entry and, if one is found, links a nonzero
// parent to it and marks it end-of-chain. The response waits while the output holds a result.
// Reset starts a clearing pass over all MAX_ENTRIES entries, one entry per cycle, with no item
// accepted meanwhile; configuration writes are taken during it.
module fat_cluster_allocator_top
    import fca_pkg::*;
#(
    parameter int MAX_ENTRIES = 65536
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [SPF_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_command,
    input  logic [CLUSTER_W-1:0] i_cluster,
    input  logic [ENTRY_W-1:0]   i_entry_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_status,
    output logic [ENTRY_W-1:0]   o_result_cluster
);

    `include "assert_macros.svh"

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int LW   = AW + 1;
    localparam int CMPW = (LW > CLUSTER_W) ? LW : CLUSTER_W;
    localparam int PW   = (LW > SPF_W + SECTOR_SHIFT) ? LW : SPF_W + SECTOR_SHIFT;
    localparam int RST_ENTRIES =
        (SPF_RESET * ENTRIES_PER_SECTOR > MAX_ENTRIES) ?
        MAX_ENTRIES : SPF_RESET * ENTRIES_PER_SECTOR;

    t_state                r_state, n_state;
    logic [1:0]            r_cmd, n_cmd;
    logic [CLUSTER_W-1:0]  r_idx, n_idx;
    logic [ENTRY_W-1:0]    r_val, n_val;
    logic [LW-1:0]         r_limit;
    logic [LW-1:0]         r_hint, n_hint;
    logic [LW-1:0]         r_scan_addr, n_scan_addr;
    logic [AW-1:0]         r_chk_addr, n_chk_addr;
    logic                  r_chk_valid, n_chk_valid;
    logic [AW-1:0]         r_found, n_found;
    logic [AW-1:0]         r_clr_addr, n_clr_addr;
    t_status               r_res_status, n_res_status;
    logic [ENTRY_W-1:0]    r_res_cluster, n_res_cluster;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [ENTRY_W-1:0]    r_out_cluster, n_out_cluster;

    logic [PW-1:0]         w_cfg_prod;
    logic [LW-1:0]         w_cfg_limit;
    logic                  w_idx_in_rng;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [ENTRY_W-1:0]    w_wdata;
    logic [AW-1:0]         w_raddr;
    logic [ENTRY_W-1:0]    w_rdata;

    fca_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENTRY_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Table size is sectors times 128, capped at the RAM depth.
    assign w_cfg_prod  = PW'(i_cfg_data) << SECTOR_SHIFT;
    assign w_cfg_limit = (w_cfg_prod > PW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES)
                                                         : LW'(w_cfg_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LW'(RST_ENTRIES);
        end else if (i_cfg_we) begin
            r_limit <= w_cfg_limit;
        end
    end

    assign w_idx_in_rng = CMPW'(r_idx) < CMPW'(r_limit);
    assign o_in_ready   = (r_state == S_IDLE);

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_val         = r_val;
        n_hint        = r_hint;
        n_scan_addr   = r_scan_addr;
        n_chk_addr    = r_chk_addr;
        n_chk_valid   = r_chk_valid;
        n_found       = r_found;
        n_clr_addr    = r_clr_addr;
        n_res_status  = r_res_status;
        n_res_cluster = r_res_cluster;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_status  = r_out_status;
        n_out_cluster = r_out_cluster;
        w_we          = 1'b0;
        w_waddr       = AW'(r_idx);
        w_wdata       = r_val;
        w_raddr       = AW'(r_idx);

        case (r_state)
            S_CLEAR: begin
                w_we       = 1'b1;
                w_waddr    = r_clr_addr;
                w_wdata    = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_command;
                    n_idx   = i_cluster;
                    n_val   = i_entry_value;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_res_status  = ST_RANGE;
                n_res_cluster = '0;
                n_state       = S_RESP;
                case (r_cmd)
                    CMD_QUERY: begin
                        if (w_idx_in_rng) begin
                            n_state = S_QDATA;
                        end
                    end
                    CMD_LOAD: begin
                        if (w_idx_in_rng) begin
                            w_we         = 1'b1;
                            n_res_status = ST_OK;
                        end
                    end
                    CMD_ALLOC: begin
                        if (r_idx == '0 || w_idx_in_rng) begin
                            n_scan_addr = r_hint;
                            n_chk_valid = 1'b0;
                            n_state     = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_QDATA: begin
                n_res_status  = ST_OK;
                n_res_cluster = w_rdata;
                n_state       = S_RESP;
            end
            S_SCAN: begin
                // Reads are issued one per cycle; each is checked in the next cycle.
                w_raddr = r_scan_addr[AW-1:0];
                if (r_chk_valid && w_rdata == '0) begin
                    n_found = r_chk_addr;
                    n_state = S_LINK;
                end else if (r_scan_addr < r_limit) begin
                    n_chk_addr  = r_scan_addr[AW-1:0];
                    n_chk_valid = 1'b1;
                    n_scan_addr = r_scan_addr + LW'(1);
                end else begin
                    n_res_status  = ST_NOT_FOUND;
                    n_res_cluster = '0;
                    n_state       = S_RESP;
                end
            end
            S_LINK: begin
                // The parent link goes in first, so a parent equal to the new
                // cluster still ends as end-of-chain.
                w_we    = (r_idx != '0);
                w_wdata = ENTRY_W'(r_found);
                n_state = S_MARK;
            end
            S_MARK: begin
                w_we          = 1'b1;
                w_waddr       = r_found;
                w_wdata       = END_OF_CHAIN;
                n_hint        = {1'b0, r_found} + LW'(1);
                n_res_status  = ST_OK;
                n_res_cluster = ENTRY_W'(r_found);
                n_state       = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_cluster = r_res_cluster;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_hint      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_hint      <= n_hint;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_idx         <= n_idx;
        r_val         <= n_val;
        r_scan_addr   <= n_scan_addr;
        r_chk_addr    <= n_chk_addr;
        r_found       <= n_found;
        r_res_status  <= n_res_status;
        r_res_cluster <= n_res_cluster;
        r_out_status  <= n_out_status;
        r_out_cluster <= n_out_cluster;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_result_cluster = r_out_cluster;

    `AST_PROP(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "ready held high after an accepted item")
    `AST_PROP(a_scan_in_table, i_clk, i_rst_n, (r_state == S_SCAN && r_chk_valid) |-> ({1'b0, r_chk_addr} < r_limit), "scan checked an entry beyond the table in use")
    `AST_NEVER(a_no_write_in_scan, i_clk, i_rst_n, (r_state == S_SCAN) && w_we, "table written during a scan")

endmodule

/* verif/tb_fat_cluster_allocator_top.sv */
// Self-checking testbench for the FAT cluster allocator: directed table, then random commands.
module tb_fat_cluster_allocator_top
    import fca_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 65536;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES = 7;
    localparam int PHASE_SPF [PHASES] = '{1, 0, 3, 1023, 2, 512, 6};
    localparam int PHASE_ITEMS [PHASES] = '{140, 15, 90, 80, 40, 90, 70};
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        t_status              status;
        logic [ENTRY_W-1:0]   cluster;
    } t_outcome;

    typedef struct {
        bit                   is_cfg;
        logic [SPF_W-1:0]     spf;
        logic [1:0]           cmd;
        logic [CLUSTER_W-1:0] cluster;
        logic [ENTRY_W-1:0]   value;
        bit                   typed;
        t_outcome             known;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [SPF_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_command = '0;
    logic [CLUSTER_W-1:0] i_cluster = '0;
    logic [ENTRY_W-1:0]   i_entry_value = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [1:0]           o_status;
    logic [ENTRY_W-1:0]   o_result_cluster;

    // Shadow copy of the cluster table, hint and sector count.
    logic [ENTRY_W-1:0]   fat_model [TABLE_DEPTH];
    logic [16:0]          hint_model;
    logic [SPF_W-1:0]     spf_model;

    t_outcome             pending_results [$];
    t_step                directed_steps [DIRECTED_ROWS];
    bit                   sender_quiet = 1'b0;
    bit                   receiver_quiet = 1'b0;
    int                   mismatches = 0;

    fat_cluster_allocator_top #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_cluster       (i_cluster),
        .i_entry_value   (i_entry_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_result_cluster(o_result_cluster)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int idle_cycles(bit quiet);
        return quiet ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic int table_size();
        int n;
        n = int'(spf_model) * ENTRIES_PER_SECTOR;
        return (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    endfunction

    // Applies one command to the shadow table and returns the result it must produce.
    function automatic t_outcome predict_command(logic [1:0] cmd, logic [CLUSTER_W-1:0] idx,
                                                 logic [ENTRY_W-1:0] val);
        t_outcome res;
        int lim;
        int c;
        lim = table_size();
        res.status = ST_RANGE;
        res.cluster = '0;
        case (cmd)
            CMD_QUERY: begin
                if (int'(idx) < lim) begin
                    res.status = ST_OK;
                    res.cluster = fat_model[idx];
                end
            end
            CMD_LOAD: begin
                if (int'(idx) < lim) begin
                    res.status = ST_OK;
                    fat_model[idx] = val;
                end
            end
            CMD_ALLOC: begin
                if (idx == '0 || int'(idx) < lim) begin
                    res.status = ST_NOT_FOUND;
                    c = int'(hint_model);
                    while (c < lim && fat_model[c] != '0) c++;
                    if (c < lim) begin
                        // The parent link goes first, so a parent equal to the new
                        // cluster ends up marked end-of-chain.
                        if (idx != '0) fat_model[idx] = ENTRY_W'(c);
                        fat_model[c] = END_OF_CHAIN;
                        hint_model = 17'(c + 1);
                        res.status = ST_OK;
                        res.cluster = ENTRY_W'(c);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_step blank_row();
        t_step s;
        s.is_cfg = 1'b0;
        s.spf = '0;
        s.cmd = '0;
        s.cluster = '0;
        s.value = '0;
        s.typed = 1'b0;
        s.known = '0;
        return s;
    endfunction

    function automatic t_step cfg_row(logic [SPF_W-1:0] spf);
        t_step s;
        s = blank_row();
        s.is_cfg = 1'b1;
        s.spf = spf;
        return s;
    endfunction

    function automatic t_step plain_row(logic [1:0] cmd, logic [CLUSTER_W-1:0] cl,
                                        logic [ENTRY_W-1:0] val);
        t_step s;
        s = blank_row();
        s.cmd = cmd;
        s.cluster = cl;
        s.value = val;
        return s;
    endfunction

    function automatic t_step known_row(logic [1:0] cmd, logic [CLUSTER_W-1:0] cl,
                                        logic [ENTRY_W-1:0] val, t_status st,
                                        logic [ENTRY_W-1:0] res);
        t_step s;
        s = plain_row(cmd, cl, val);
        s.typed = 1'b1;
        s.known.status = st;
        s.known.cluster = res;
        return s;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [SPF_W-1:0] spf);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_data <= spf;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        spf_model = spf;
    endtask

    // Valid is lowered here only when a gap is drawn, so back-to-back items keep it high.
    task automatic send_command(logic [1:0] cmd, logic [CLUSTER_W-1:0] cl,
                                logic [ENTRY_W-1:0] val, bit typed, t_outcome known);
        int gap;
        t_outcome predicted;
        gap = idle_cycles(sender_quiet);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_cluster <= cl;
        i_entry_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = predict_command(cmd, cl, val);
        pending_results.push_back(typed ? known : predicted);
    endtask

    task automatic send_random_command();
        int pick;
        int lim;
        int near;
        logic [1:0] cmd;
        logic [CLUSTER_W-1:0] cl;
        logic [ENTRY_W-1:0] val;
        lim = table_size();
        pick = $urandom_range(0, 99);
        if (pick < 45) cmd = CMD_ALLOC;
        else if (pick < 75) cmd = CMD_LOAD;
        else if (pick < 95) cmd = CMD_QUERY;
        else cmd = CMD_UNUSED;

        pick = $urandom_range(0, 9);
        if (pick == 0 || lim == 0) begin
            cl = CLUSTER_W'($urandom);
        end else if (cmd == CMD_ALLOC && pick < 5) begin
            cl = '0;
        end else if (cmd == CMD_LOAD && pick < 6) begin
            // Loads just ahead of the hint make the allocation scan skip entries.
            near = int'(hint_model) + $urandom_range(0, 15);
            cl = (near > TABLE_DEPTH - 1) ? '1 : CLUSTER_W'(near);
        end else begin
            cl = CLUSTER_W'($urandom_range(0, lim - 1));
        end

        case ($urandom_range(0, 3))
            0: val = '0;
            1: val = END_OF_CHAIN;
            2: val = ENTRY_W'($urandom_range(1, 1024));
            default: val = ENTRY_W'($urandom);
        endcase
        send_command(cmd, cl, val, 1'b0, '0);
    endtask

    initial begin
        for (int k = 0; k < TABLE_DEPTH; k++) fat_model[k] = '0;
        hint_model = '0;
        spf_model = SPF_W'(SPF_RESET);

        directed_steps = '{
            known_row(CMD_QUERY, 16'd0, 28'd0, ST_OK, 28'd0),
            known_row(CMD_QUERY, 16'hFFFF, 28'hFFFFFFF, ST_OK, 28'd0),
            known_row(CMD_ALLOC, 16'd0, 28'd0, ST_OK, 28'd0),
            known_row(CMD_QUERY, 16'd0, 28'd0, ST_OK, END_OF_CHAIN),
            known_row(CMD_ALLOC, 16'd1, 28'd0, ST_OK, 28'd1),
            known_row(CMD_QUERY, 16'd1, 28'd0, ST_OK, END_OF_CHAIN),
            known_row(CMD_LOAD, 16'd2, END_OF_CHAIN, ST_OK, 28'd0),
            known_row(CMD_LOAD, 16'hFFFF, 28'h0F0F0F0, ST_OK, 28'd0),
            plain_row(CMD_ALLOC, 16'hFFFF, 28'd0),
            known_row(CMD_QUERY, 16'hFFFF, 28'd0, ST_OK, 28'd3),
            known_row(CMD_UNUSED, 16'd5, 28'd7, ST_RANGE, 28'd0),
            plain_row(CMD_LOAD, 16'd4, 28'd0),
            cfg_row(10'd1),
            known_row(CMD_QUERY, 16'd128, 28'd0, ST_RANGE, 28'd0),
            known_row(CMD_LOAD, 16'd128, 28'd1, ST_RANGE, 28'd0),
            known_row(CMD_ALLOC, 16'd128, 28'd0, ST_RANGE, 28'd0),
            plain_row(CMD_ALLOC, 16'd127, 28'd0),
            plain_row(CMD_QUERY, 16'd127, 28'd0),
            cfg_row(10'd0),
            known_row(CMD_ALLOC, 16'd0, 28'd0, ST_NOT_FOUND, 28'd0),
            known_row(CMD_QUERY, 16'd0, 28'd0, ST_RANGE, 28'd0),
            known_row(CMD_ALLOC, 16'd5, 28'd0, ST_RANGE, 28'd0),
            cfg_row(10'd1023),
            plain_row(CMD_QUERY, 16'hFFFF, 28'd0),
            plain_row(CMD_ALLOC, 16'd0, 28'd0)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The first item waits out the clearing pass through the handshake.
        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_cfg) begin
                reconfigure(directed_steps[i].spf);
            end else begin
                send_command(directed_steps[i].cmd, directed_steps[i].cluster,
                             directed_steps[i].value, directed_steps[i].typed,
                             directed_steps[i].known);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            reconfigure(SPF_W'(PHASE_SPF[p]));
            sender_quiet = (p == 2 || p == 5);
            receiver_quiet = (p == 3 || p == 5);
            repeat (PHASE_ITEMS[p]) begin
                if ($urandom_range(0, 39) == 0) drain_results();
                send_random_command();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int stall;
        t_outcome want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = idle_cycles(receiver_quiet);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item: status %0d cluster 0x%0h",
                                          o_status, o_result_cluster));
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
                end
                if (o_result_cluster !== want.cluster) begin
                    report_mismatch($sformatf("cluster 0x%0h, expected 0x%0h",
                                              o_result_cluster, want.cluster));
                end
            end
        end
    end

endmodule
